>>> rtl/core/tsrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsrg_pkg
// Shared types, codes and constants of the text screen refresh governor.
// ----------------------------------------------------------------------------
package tsrg_pkg;

    localparam int CELLS    = 2000;
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int SUM_W    = 20;
    localparam int TMO_W    = 10;
    localparam int STEP_W   = 8;
    localparam int LIMIT_W  = 4;
    localparam int PAGE_W   = 20;
    localparam int COLOR_W  = 8;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int PROD_W   = LIMIT_W + STEP_W;

    localparam logic [KIND_W-1:0] KIND_SCAN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CELL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BIOS  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INPUT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SCAN    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CELL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DECIDED = 2'd3;

    localparam logic [1:0] REG_CHANGED  = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;
    localparam logic [1:0] REG_GRAPHICS = 2'd3;

    localparam logic [TMO_W-1:0]   RST_CHANGED  = 10'd100;
    localparam logic [STEP_W-1:0]  RST_STEP     = 8'd30;
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = 4'd10;
    localparam logic [TMO_W-1:0]   RST_GRAPHICS = 10'd10;

    localparam logic [PAGE_W-1:0]  TEXT_PAGE_LO = 20'h000B8;
    localparam logic [PAGE_W-1:0]  TEXT_PAGE_HI = 20'h000BF;
    localparam logic [3:0]         FG_DARK_GRAY = 4'h8;
    localparam logic [3:0]         FG_GRAY      = 4'h7;
    localparam logic [COLOR_W-1:0] COLOR_HALF   = 8'd127;
    localparam logic [LIMIT_W-1:0] UC_MAX       = 4'hF;
    localparam logic [TMO_W-1:0]   TMO_MAX      = 10'h3FF;

    typedef struct packed {
        logic [TMO_W-1:0]   changed_timeout_ms;
        logic [STEP_W-1:0]  backoff_step_ms;
        logic [LIMIT_W-1:0] unchanged_limit;
        logic [TMO_W-1:0]   graphics_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic                     buffer_present;
        logic                     text_display;
        logic signed [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0]        attribute;
        logic                     last_cell;
        logic [PAGE_W-1:0]        fault_page;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TMO_W-1:0]    timeout_ms;
        logic                refresh;
        logic                unmap_text;
        logic                map_graphics;
        logic                arm_timer;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } result_t;

    function automatic logic [COLOR_W-1:0] fg_level(input logic hue, input logic lum);
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] b;
        a = hue ? COLOR_HALF : '0;
        b = lum ? COLOR_HALF : '0;
        return a + b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tsrg_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsrg_item_if / tsrg_result_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface tsrg_item_if;
    import tsrg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic                     buffer_present;
    logic                     text_display;
    logic signed [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0]        attribute;
    logic                     last_cell;
    logic [PAGE_W-1:0]        fault_page;

    modport source (
        output valid, kind, buffer_present, text_display, char_code, attribute,
               last_cell, fault_page,
        input  ready
    );
    modport sink (
        input  valid, kind, buffer_present, text_display, char_code, attribute,
               last_cell, fault_page,
        output ready
    );
endinterface

interface tsrg_result_if;
    import tsrg_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TMO_W-1:0]    timeout_ms;
    logic                refresh;
    logic                unmap_text;
    logic                map_graphics;
    logic                arm_timer;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;

    modport source (
        output valid, status, timeout_ms, refresh, unmap_text, map_graphics,
               arm_timer, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, status, timeout_ms, refresh, unmap_text, map_graphics,
               arm_timer, red, green, blue,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/tsrg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsrg_regs
// APB register file holding the timing and backoff settings.
// ----------------------------------------------------------------------------
module tsrg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsrg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tsrg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tsrg_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output tsrg_pkg::cfg_t                     cfg
);
    import tsrg_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.changed_timeout_ms  <= RST_CHANGED;
            cfg_reg.backoff_step_ms     <= RST_STEP;
            cfg_reg.unchanged_limit     <= RST_LIMIT;
            cfg_reg.graphics_timeout_ms <= RST_GRAPHICS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CHANGED:  cfg_reg.changed_timeout_ms  <= pwdata[TMO_W-1:0];
                REG_STEP:     cfg_reg.backoff_step_ms     <= pwdata[STEP_W-1:0];
                REG_LIMIT:    cfg_reg.unchanged_limit     <= pwdata[LIMIT_W-1:0];
                REG_GRAPHICS: cfg_reg.graphics_timeout_ms <= pwdata[TMO_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CHANGED:  prdata = PDATA_W'(cfg_reg.changed_timeout_ms);
            REG_STEP:     prdata = PDATA_W'(cfg_reg.backoff_step_ms);
            REG_LIMIT:    prdata = PDATA_W'(cfg_reg.unchanged_limit);
            REG_GRAPHICS: prdata = PDATA_W'(cfg_reg.graphics_timeout_ms);
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/tsrg_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsrg_core
// Governor state and the per-word decision logic: scan start, graphics switch,
// cell color and checksum, frame decision with backoff, reactivation.
// ----------------------------------------------------------------------------
module tsrg_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire tsrg_pkg::cfg_t   cfg,
    input  wire tsrg_pkg::item_t  item,
    output tsrg_pkg::result_t     result
);
    import tsrg_pkg::*;

    logic               active_reg,    active_next;
    logic               revoked_reg,   revoked_next;
    logic               bios_reg,      bios_next;
    logic               even_reg,      even_next;
    logic               open_reg,      open_next;
    logic [SUM_W-1:0]   sum_even_reg,  sum_even_next;
    logic [SUM_W-1:0]   sum_odd_reg,   sum_odd_next;
    logic [LIMIT_W-1:0] uc_reg,        uc_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;

    logic [3:0]         fg;
    logic [SUM_W-1:0]   sum_new;
    logic [SUM_W-1:0]   sum_other;
    logic [CNT_W:0]     cnt_inc;
    logic [LIMIT_W-1:0] uc_inc;
    logic [PROD_W-1:0]  prod;
    logic               in_text_pages;

    assign fg        = (item.attribute[3:0] == FG_DARK_GRAY) ? FG_GRAY : item.attribute[3:0];
    assign sum_new   = (even_reg ? sum_even_reg : sum_odd_reg)
                       + SUM_W'(signed'(item.char_code));
    assign sum_other = even_reg ? sum_odd_reg : sum_even_reg;
    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;
    assign uc_inc    = (uc_reg == UC_MAX) ? UC_MAX : uc_reg + 1'b1;
    assign prod      = PROD_W'(uc_inc) * PROD_W'(cfg.backoff_step_ms);
    assign in_text_pages = (item.fault_page >= TEXT_PAGE_LO) && (item.fault_page <= TEXT_PAGE_HI);

    always_comb
    begin
        active_next   = active_reg;
        revoked_next  = revoked_reg;
        bios_next     = bios_reg;
        even_next     = even_reg;
        open_next     = open_reg;
        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        uc_next       = uc_reg;
        cnt_next      = cnt_reg;
        result        = '0;

        unique case (item.kind)
            KIND_SCAN:
            begin
                if (item.buffer_present)
                begin
                    if (item.text_display)
                    begin
                        if (active_reg && !revoked_reg)
                        begin
                            if (even_reg)
                                sum_even_next = '0;
                            else
                                sum_odd_next = '0;
                            open_next     = 1'b1;
                            cnt_next      = '0;
                            result.status = ST_SCAN;
                        end
                    end
                    else
                    begin
                        open_next = 1'b0;
                        if (!revoked_reg)
                        begin
                            result.map_graphics = 1'b1;
                            revoked_next        = 1'b1;
                        end
                        result.status     = ST_SCAN;
                        result.timeout_ms = cfg.graphics_timeout_ms;
                        result.refresh    = 1'b1;
                    end
                end
            end
            KIND_CELL:
            begin
                if (open_reg)
                begin
                    result.red   = fg_level(fg[2], fg[3]);
                    result.green = fg_level(fg[1], fg[3]);
                    result.blue  = fg_level(fg[0], fg[3]);
                    if (even_reg)
                        sum_even_next = sum_new;
                    else
                        sum_odd_next = sum_new;
                    cnt_next      = cnt_inc[CNT_W-1:0];
                    result.status = ST_CELL;
                    if (item.last_cell || (cnt_inc >= (CNT_W+1)'(CELLS)))
                    begin
                        open_next     = 1'b0;
                        cnt_next      = '0;
                        even_next     = !even_reg;
                        result.status = ST_DECIDED;
                        if (sum_new != sum_other)
                        begin
                            uc_next           = '0;
                            result.timeout_ms = cfg.changed_timeout_ms;
                            result.refresh    = 1'b1;
                        end
                        else if (uc_inc < cfg.unchanged_limit)
                        begin
                            uc_next           = uc_inc;
                            result.timeout_ms = (|prod[PROD_W-1:TMO_W]) ? TMO_MAX
                                                                       : prod[TMO_W-1:0];
                        end
                        else
                        begin
                            uc_next           = '0;
                            active_next       = 1'b0;
                            result.unmap_text = 1'b1;
                        end
                    end
                end
            end
            KIND_FAULT:
            begin
                bios_next = 1'b0;
                if (in_text_pages || (bios_reg && !active_reg))
                begin
                    active_next      = 1'b1;
                    result.arm_timer = 1'b1;
                end
            end
            KIND_BIOS:
            begin
                bios_next = 1'b1;
            end
            KIND_INPUT:
            begin
                if (!active_reg)
                begin
                    active_next      = 1'b1;
                    result.arm_timer = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            revoked_reg  <= 1'b0;
            bios_reg     <= 1'b0;
            even_reg     <= 1'b1;
            open_reg     <= 1'b0;
            sum_even_reg <= '0;
            sum_odd_reg  <= '0;
            uc_reg       <= '0;
            cnt_reg      <= '0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            revoked_reg  <= revoked_next;
            bios_reg     <= bios_next;
            even_reg     <= even_next;
            open_reg     <= open_next;
            sum_even_reg <= sum_even_next;
            sum_odd_reg  <= sum_odd_next;
            uc_reg       <= uc_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/text_screen_refresh_governor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_screen_refresh_governor
// Refresh governor for an emulated text screen: input stage, decision core,
// result register and APB settings.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. The input stage holds the
// accepted word and feeds the decision core, which updates the governor state
// and loads the result register together, so the result word is registered
// behind the input stage. One word is taken per clock while the result is not
// stalled by a low result ready. A waiting result does not block the input
// stage from holding the next word. The user must write settings over APB only
// while no words are in flight; the block itself does not enforce this.
module text_screen_refresh_governor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tsrg_item_if.sink                          item,
    tsrg_result_if.source                      result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsrg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tsrg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tsrg_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import tsrg_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg;
    logic    load;

    assign load       = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || load;

    tsrg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsrg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (load),
        .cfg    (cfg),
        .item   (in_reg),
        .result (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg.kind           <= item.kind;
            in_reg.buffer_present <= item.buffer_present;
            in_reg.text_display   <= item.text_display;
            in_reg.char_code      <= item.char_code;
            in_reg.attribute      <= item.attribute;
            in_reg.last_cell      <= item.last_cell;
            in_reg.fault_page     <= item.fault_page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_comb;
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = res_reg.status;
    assign result.timeout_ms   = res_reg.timeout_ms;
    assign result.refresh      = res_reg.refresh;
    assign result.unmap_text   = res_reg.unmap_text;
    assign result.map_graphics = res_reg.map_graphics;
    assign result.arm_timer    = res_reg.arm_timer;
    assign result.red          = res_reg.red;
    assign result.green        = res_reg.green;
    assign result.blue         = res_reg.blue;

endmodule
`default_nettype wire
